### hw/rtl/rsi_pkg.sv
// Shared types for the ray/sphere intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

    // Per-beat control that rides alongside the datapath through every stage.
    typedef struct packed {
        logic vld;
        logic far;
        logic nohit;
        logic neg;
    } rsi_ctl_t;

endpackage

### hw/rtl/rsi_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per beat.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_sqrt_cell #(
    parameter int SW     = 65,
    parameter int SIDE_W = 129
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rsi_pkg::rsi_ctl_t     up_ctl,
    input  logic [2*SW-1:0]       up_rad,
    input  logic [SW:0]           up_rem,
    input  logic [SW-1:0]         up_root,
    input  logic [SIDE_W-1:0]     up_side,
    output rsi_pkg::rsi_ctl_t     dn_ctl,
    output logic [2*SW-1:0]       dn_rad,
    output logic [SW:0]           dn_rem,
    output logic [SW-1:0]         dn_root,
    output logic [SIDE_W-1:0]     dn_side
);

    rsi_pkg::rsi_ctl_t  ctl_reg;
    logic [2*SW-1:0]    rad_reg, rad_next;
    logic [SW:0]        rem_reg, rem_next;
    logic [SW-1:0]      root_reg, root_next;
    logic [SIDE_W-1:0]  side_reg;
    logic [SW+2:0]      r2, trial, diff;
    logic               ge;

    always_comb
    begin
        r2        = {up_rem, up_rad[2*SW-1 -: 2]};
        trial     = {1'b0, up_root, 2'b01};
        ge        = (r2 >= trial);
        diff      = r2 - trial;
        rem_next  = ge ? diff[SW:0] : r2[SW:0];
        root_next = {up_root[SW-2:0], ge};
        rad_next  = {up_rad[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= up_side;
        end
    end

    assign dn_ctl  = ctl_reg;
    assign dn_rad  = rad_reg;
    assign dn_rem  = rem_reg;
    assign dn_root = root_reg;
    assign dn_side = side_reg;

endmodule

### hw/rtl/rsi_div_cell.sv
// One restoring divider cell: resolves one quotient bit per beat.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_div_cell #(
    parameter int AW = 64,
    parameter int QW = 82
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rsi_pkg::rsi_ctl_t     up_ctl,
    input  logic [AW-1:0]         up_den,
    input  logic [QW-1:0]         up_num,
    input  logic [AW-1:0]         up_rem,
    input  logic [QW-1:0]         up_quo,
    output rsi_pkg::rsi_ctl_t     dn_ctl,
    output logic [AW-1:0]         dn_den,
    output logic [QW-1:0]         dn_num,
    output logic [AW-1:0]         dn_rem,
    output logic [QW-1:0]         dn_quo
);

    rsi_pkg::rsi_ctl_t  ctl_reg;
    logic [AW-1:0]      den_reg;
    logic [QW-1:0]      num_reg, num_next;
    logic [AW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      quo_reg, quo_next;
    logic [AW:0]        r2, diff;
    logic               ge;

    always_comb
    begin
        r2       = {up_rem, up_num[QW-1]};
        ge       = (r2 >= {1'b0, up_den});
        diff     = r2 - {1'b0, up_den};
        rem_next = ge ? diff[AW-1:0] : r2[AW-1:0];
        quo_next = {up_quo[QW-2:0], ge};
        num_next = {up_num[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= up_den;
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign dn_ctl = ctl_reg;
    assign dn_den = den_reg;
    assign dn_num = num_reg;
    assign dn_rem = rem_reg;
    assign dn_quo = quo_reg;

endmodule

### hw/rtl/ray_sphere_intersect_top.sv
// Ray/sphere intersection: front-end products, square-root cell chain, divider cell chain.
// Depends on rsi_pkg, rsi_sqrt_cell, rsi_div_cell.
`timescale 1ns / 1ps

// Fully pipelined: one beat in and one beat out per cycle when out_ready stays high.
// The pipe holds 4 front stages, one square-root cell per root bit (2*WORD_BITS+1 root
// bits, 65 at the defaults), one divider cell per quotient bit (2*WORD_BITS+FRAC_BITS+2
// quotient bits, 82 at the defaults), then the numerator stage and the output register.
// The whole pipe stalls together while a result held in the output register is not taken.

module ray_sphere_intersect_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [WORD_BITS-1:0]       dir_x,
    input  logic signed [WORD_BITS-1:0]       dir_y,
    input  logic signed [WORD_BITS-1:0]       dir_z,
    input  logic signed [WORD_BITS-1:0]       oc_x,
    input  logic signed [WORD_BITS-1:0]       oc_y,
    input  logic signed [WORD_BITS-1:0]       oc_z,
    input  logic signed [WORD_BITS+FRAC_BITS-1:0] c_term,
    input  logic                              inside_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic signed [WORD_BITS-1:0]       distance
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int CW  = W + F;
    localparam int CL  = CW / 2;
    localparam int CH  = CW - CL;
    localparam int AW  = 2 * W;
    localparam int XW  = (4 * W > 3 * W + 2 * F) ? 4 * W : 3 * W + 2 * F;
    localparam int DW  = XW + 2;
    localparam int RW  = XW + 1;
    localparam int SW  = (RW + 1) / 2;
    localparam int NW  = ((AW > SW) ? AW : SW) + 1;
    localparam int NSW = NW + 1;
    localparam int QW  = NW + F;
    localparam int SDW = AW + AW;
    localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: products
    rsi_pkg::rsi_ctl_t           s1_ctl_reg;
    logic signed [AW-1:0]        sq_reg [3];
    logic signed [AW-1:0]        dp_reg [3];
    logic signed [CW-1:0]        s1_c_reg;

    // stage 2: a and half_b
    rsi_pkg::rsi_ctl_t           s2_ctl_reg;
    logic [AW-1:0]               s2_a_reg, s2_a_next;
    logic signed [AW+1:0]        s2_hb_reg, s2_hb_next;
    logic signed [CW-1:0]        s2_c_reg;

    // stage 3: partial products
    rsi_pkg::rsi_ctl_t           s3_ctl_reg;
    logic [AW-1:0]               s3_a_reg;
    logic [AW-1:0]               s3_hm_reg, s3_hm_next;
    logic                        s3_cneg_reg;
    logic [AW-1:0]               h_ll_reg, h_lh_reg, h_hh_reg;
    logic [W+CH-1:0]             c_ll_reg, c_lh_reg, c_hl_reg, c_hh_reg;
    logic [CW-1:0]               cm;

    // stage 4: discriminant
    rsi_pkg::rsi_ctl_t           s4_ctl, s4_ctl_reg;
    logic [AW-1:0]               s4_a_reg;
    logic [AW-1:0]               s4_hm_reg;
    logic [2*SW-1:0]             s4_rad_reg, s4_rad_next;
    logic [XW-1:0]               hb2, ac;
    logic signed [DW-1:0]        dsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= '{vld: in_valid, far: inside_req, nohit: 1'b0, neg: 1'b0};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s4_ctl;
        end
    end

    always_comb
    begin
        s2_a_next  = AW'($unsigned(sq_reg[0])) + AW'($unsigned(sq_reg[1]))
                   + AW'($unsigned(sq_reg[2]));
        s2_hb_next = (AW+2)'(dp_reg[0]) + (AW+2)'(dp_reg[1]) + (AW+2)'(dp_reg[2]);
        s3_hm_next = s2_hb_reg[AW+1] ? AW'(-s2_hb_reg) : AW'(s2_hb_reg);
        cm         = s2_c_reg[CW-1] ? CW'(-s2_c_reg) : CW'(s2_c_reg);
    end

    always_comb
    begin
        hb2 = (XW'(h_hh_reg) << AW) + (XW'(h_lh_reg) << (W + 1)) + XW'(h_ll_reg);
        ac  = ((XW'(c_hh_reg) << (W + CL)) + (XW'(c_hl_reg) << W)
              + (XW'(c_lh_reg) << CL) + XW'(c_ll_reg)) << F;
        dsum = DW'(hb2) + (s3_cneg_reg ? DW'(ac) : -DW'(ac));
        s4_ctl       = s3_ctl_reg;
        s4_ctl.nohit = (s3_a_reg == '0) || dsum[DW-1];
        s4_ctl.neg   = s3_ctl_reg.neg;
        s4_rad_next  = s4_ctl.nohit ? '0 : (2*SW)'(dsum[RW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= dir_x * dir_x;
            sq_reg[1] <= dir_y * dir_y;
            sq_reg[2] <= dir_z * dir_z;
            dp_reg[0] <= dir_x * oc_x;
            dp_reg[1] <= dir_y * oc_y;
            dp_reg[2] <= dir_z * oc_z;
            s1_c_reg  <= c_term;

            s2_a_reg  <= s2_a_next;
            s2_hb_reg <= s2_hb_next;
            s2_c_reg  <= s1_c_reg;

            s3_a_reg    <= s2_a_reg;
            s3_hm_reg   <= s3_hm_next;
            s3_cneg_reg <= s2_c_reg[CW-1];
            h_ll_reg    <= AW'(s3_hm_next[W-1:0] * s3_hm_next[W-1:0]);
            h_lh_reg    <= AW'(s3_hm_next[W-1:0] * s3_hm_next[AW-1:W]);
            h_hh_reg    <= AW'(s3_hm_next[AW-1:W] * s3_hm_next[AW-1:W]);
            c_ll_reg    <= (W+CH)'(s2_a_reg[W-1:0] * cm[CL-1:0]);
            c_lh_reg    <= (W+CH)'(s2_a_reg[W-1:0] * cm[CW-1:CL]);
            c_hl_reg    <= (W+CH)'(s2_a_reg[AW-1:W] * cm[CL-1:0]);
            c_hh_reg    <= (W+CH)'(s2_a_reg[AW-1:W] * cm[CW-1:CL]);

            s4_a_reg   <= s3_a_reg;
            s4_hm_reg  <= s3_hm_reg;
            s4_rad_reg <= s4_rad_next;
        end
    end

    // half_b sign rides in ctl.neg through the root chain
    rsi_pkg::rsi_ctl_t s4_ctl_fix;
    always_comb
    begin
        s4_ctl_fix     = s4_ctl_reg;
        s4_ctl_fix.neg = 1'b0;
    end

    logic s3_hbneg_reg, s4_hbneg_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_hbneg_reg <= s2_hb_reg[AW+1];
            s4_hbneg_reg <= s3_hbneg_reg;
        end
    end

    // square-root chain
    rsi_pkg::rsi_ctl_t   sq_ctl  [SW+1];
    logic [2*SW-1:0]     sq_rad  [SW+1];
    logic [SW:0]         sq_rem  [SW+1];
    logic [SW-1:0]       sq_root [SW+1];
    logic [SDW-1:0]      sq_side [SW+1];

    always_comb
    begin
        sq_ctl[0]     = s4_ctl_fix;
        sq_ctl[0].neg = s4_hbneg_reg;
        sq_rad[0]     = s4_rad_reg;
        sq_rem[0]     = '0;
        sq_root[0]    = '0;
        sq_side[0]    = {s4_a_reg, s4_hm_reg};
    end

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        rsi_sqrt_cell #(
            .SW     (SW),
            .SIDE_W (SDW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .up_ctl  (sq_ctl[i]),
            .up_rad  (sq_rad[i]),
            .up_rem  (sq_rem[i]),
            .up_root (sq_root[i]),
            .up_side (sq_side[i]),
            .dn_ctl  (sq_ctl[i+1]),
            .dn_rad  (sq_rad[i+1]),
            .dn_rem  (sq_rem[i+1]),
            .dn_root (sq_root[i+1]),
            .dn_side (sq_side[i+1])
        );
    end

    // numerator stage
    rsi_pkg::rsi_ctl_t   s5_ctl, s5_ctl_reg;
    logic [AW-1:0]       s5_a_reg;
    logic [QW-1:0]       s5_num_reg, s5_num_next;
    logic signed [NSW-1:0] ns;
    logic [AW-1:0]       sq_a, sq_hm;
    logic [NW-1:0]       nm;

    always_comb
    begin
        sq_a  = sq_side[SW][SDW-1:AW];
        sq_hm = sq_side[SW][AW-1:0];
        ns    = (sq_ctl[SW].neg ? NSW'(sq_hm) : -NSW'(sq_hm))
              + (sq_ctl[SW].far ? NSW'(sq_root[SW]) : -NSW'(sq_root[SW]));
        nm    = ns[NSW-1] ? NW'(-ns) : NW'(ns);
        s5_ctl     = sq_ctl[SW];
        s5_ctl.neg = ns[NSW-1];
        s5_num_next = QW'(nm) << F;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s5_ctl_reg <= s5_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_a_reg   <= sq_a;
            s5_num_reg <= s5_num_next;
        end
    end

    // divider chain
    rsi_pkg::rsi_ctl_t   dv_ctl [QW+1];
    logic [AW-1:0]       dv_den [QW+1];
    logic [QW-1:0]       dv_num [QW+1];
    logic [AW-1:0]       dv_rem [QW+1];
    logic [QW-1:0]       dv_quo [QW+1];

    always_comb
    begin
        dv_ctl[0] = s5_ctl_reg;
        dv_den[0] = s5_a_reg;
        dv_num[0] = s5_num_reg;
        dv_rem[0] = '0;
        dv_quo[0] = '0;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        rsi_div_cell #(
            .AW (AW),
            .QW (QW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .up_ctl (dv_ctl[j]),
            .up_den (dv_den[j]),
            .up_num (dv_num[j]),
            .up_rem (dv_rem[j]),
            .up_quo (dv_quo[j]),
            .dn_ctl (dv_ctl[j+1]),
            .dn_den (dv_den[j+1]),
            .dn_num (dv_num[j+1]),
            .dn_rem (dv_rem[j+1]),
            .dn_quo (dv_quo[j+1])
        );
    end

    // saturate and register result
    logic              hit_reg, hit_next;
    logic [W-1:0]      dist_reg, dist_next;
    rsi_pkg::rsi_ctl_t fin;
    logic [QW-1:0]     q;

    always_comb
    begin
        fin = dv_ctl[QW];
        q   = dv_quo[QW];
        if (fin.neg)
        begin
            dist_next = (q > LIM) ? {1'b1, {(W-1){1'b0}}} : W'(-q);
        end
        else
        begin
            dist_next = (q > LIM - QW'(1)) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
        end
        hit_next = !fin.nohit;
        if (fin.nohit)
        begin
            dist_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign distance  = dist_reg;

endmodule
